// File: rtl/grouped_priority_dispatcher_core_assert.svh
// ----------------------------------------------------------------------------
// grouped_priority_dispatcher_core_assert
// Assertion macros used by the dispatcher core RTL.
// ----------------------------------------------------------------------------
`ifndef GROUPED_PRIORITY_DISPATCHER_CORE_ASSERT_SVH
`define GROUPED_PRIORITY_DISPATCHER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dispatcher assertion failed");

// Next-cycle implication, checked out of reset.
`define GPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dispatcher assertion failed");

`endif

// File: rtl/gpd_pkg.sv
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared sizes, codes and types of the grouped priority dispatcher.
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int JOB_SLOTS  = 64;
  localparam int LOCK_SLOTS = 16;
  localparam int SLOT_W     = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int LOCK_W     = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
  localparam int IDENT_W    = 64;
  localparam int PRIO_W     = 8;
  localparam int GROUP_W    = 32;
  localparam int CNT_W      = 8;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LOCK   = 2'd1;
  localparam logic [1:0] ACT_UNLOCK = 2'd2;
  localparam logic [1:0] ACT_DISP   = 2'd3;

  localparam logic [1:0] CAT_JUDGE   = 2'd0;
  localparam logic [1:0] CAT_PROBLEM = 2'd1;
  localparam logic [1:0] CAT_OTHER   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NONE      = 3'd1;
  localparam logic [2:0] ST_JOB_FULL  = 3'd2;
  localparam logic [2:0] ST_DUP       = 3'd3;
  localparam logic [2:0] ST_NOT_LOCKD = 3'd4;
  localparam logic [2:0] ST_LOCK_FULL = 3'd5;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic               local_free;
    logic               judge_free;
  } req_t;

  typedef struct packed {
    logic [IDENT_W-1:0] ident;
    logic [PRIO_W-1:0]  prio;
    logic [GROUP_W-1:0] group;
    logic [1:0]         cat;
    logic               locks;
  } entry_t;

  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [PRIO_W-1:0]  prio;
    logic [IDENT_W-1:0] ident;
    logic [GROUP_W-1:0] group;
    logic [1:0]         cat;
    logic               locks;
    logic [SLOT_W-1:0]  slot;
    logic               dup;
    logic               free_hit;
    logic [SLOT_W-1:0]  free_slot;
  } scan_t;

  typedef struct packed {
    logic found;
    logic possible;
  } lock_stat_t;

endpackage

// File: rtl/gpd_job_cell.sv
// ----------------------------------------------------------------------------
// gpd_job_cell
// One job slot; folds its entry into the scan beat passing down the chain.
// ----------------------------------------------------------------------------
module gpd_job_cell (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [gpd_pkg::SLOT_W-1:0]                slot_i,
  input  logic                                      set_i,
  input  logic                                      clr_i,
  input  gpd_pkg::entry_t                           wr_i,
  input  gpd_pkg::req_t                             req_i,
  input  logic [gpd_pkg::LOCK_SLOTS-1:0]            lk_vld_i,
  input  logic [gpd_pkg::LOCK_SLOTS-1:0][gpd_pkg::GROUP_W-1:0] lk_grp_i,
  input  gpd_pkg::scan_t                            scan_i,
  output gpd_pkg::scan_t                            scan_o
);
  import gpd_pkg::*;

  logic   valid_q;
  entry_t ent_q;
  scan_t  scan_d, scan_q;
  logic   locked, elig, better;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (set_i) begin
      valid_q <= 1'b1;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_i) begin
      ent_q <= wr_i;
    end
  end

  always_comb begin
    locked = 1'b0;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (lk_vld_i[i] && lk_grp_i[i] == ent_q.group) begin
        locked = 1'b1;
      end
    end
    unique case (ent_q.cat)
      CAT_JUDGE:   elig = valid_q && req_i.judge_free && !locked;
      CAT_PROBLEM: elig = valid_q && req_i.local_free && !locked;
      default:     elig = valid_q && req_i.local_free;
    endcase
    better = !scan_i.hit || ent_q.prio > scan_i.prio ||
             (ent_q.prio == scan_i.prio && ent_q.ident < scan_i.ident);
    scan_d = scan_i;
    if (elig && better) begin
      scan_d.hit   = 1'b1;
      scan_d.prio  = ent_q.prio;
      scan_d.ident = ent_q.ident;
      scan_d.group = ent_q.group;
      scan_d.cat   = ent_q.cat;
      scan_d.locks = ent_q.locks;
      scan_d.slot  = slot_i;
    end
    if (valid_q && ent_q.ident == req_i.ident) begin
      scan_d.dup = 1'b1;
    end
    if (!valid_q && !scan_i.free_hit) begin
      scan_d.free_hit  = 1'b1;
      scan_d.free_slot = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

// File: rtl/gpd_lock_table.sv
// ----------------------------------------------------------------------------
// gpd_lock_table
// Group lock counts: lookup, take and release of one lock per cycle.
// ----------------------------------------------------------------------------
module gpd_lock_table (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [gpd_pkg::GROUP_W-1:0]               group_i,
  input  logic                                      take_i,
  input  logic                                      release_i,
  output gpd_pkg::lock_stat_t                       stat_o,
  output logic [gpd_pkg::LOCK_SLOTS-1:0]            lk_vld_o,
  output logic [gpd_pkg::LOCK_SLOTS-1:0][gpd_pkg::GROUP_W-1:0] lk_grp_o
);
  import gpd_pkg::*;

  logic [LOCK_SLOTS-1:0]              vld_q;
  logic [LOCK_SLOTS-1:0][GROUP_W-1:0] grp_q;
  logic [LOCK_SLOTS-1:0][CNT_W-1:0]   cnt_q;
  logic                               found, free_hit;
  logic [LOCK_W-1:0]                  fidx, free_idx;

  always_comb begin
    found    = 1'b0;
    free_hit = 1'b0;
    fidx     = '0;
    free_idx = '0;
    for (int i = 0; i < LOCK_SLOTS; i++) begin
      if (!found && vld_q[i] && grp_q[i] == group_i) begin
        found = 1'b1;
        fidx  = LOCK_W'(i);
      end
      if (!free_hit && !vld_q[i]) begin
        free_hit = 1'b1;
        free_idx = LOCK_W'(i);
      end
    end
    stat_o.found    = found;
    stat_o.possible = found ? (cnt_q[fidx] != {CNT_W{1'b1}}) : free_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (take_i && !found) begin
      vld_q[free_idx] <= 1'b1;
    end else if (release_i && cnt_q[fidx] == CNT_W'(1)) begin
      vld_q[fidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      if (found) begin
        cnt_q[fidx] <= cnt_q[fidx] + CNT_W'(1);
      end else begin
        grp_q[free_idx] <= group_i;
        cnt_q[free_idx] <= CNT_W'(1);
      end
    end else if (release_i) begin
      cnt_q[fidx] <= cnt_q[fidx] - CNT_W'(1);
    end
  end

  assign lk_vld_o = vld_q;
  assign lk_grp_o = grp_q;

endmodule

// File: rtl/grouped_priority_dispatcher_core.sv
// ----------------------------------------------------------------------------
// grouped_priority_dispatcher_core
// Pending-job table with group locks and priority dispatch.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one command per beat: add a
// job, lock a group, unlock a group or request a dispatch. Every command
// gives exactly one result beat on the output channel (out_valid_o /
// out_ready_i) with a status code and, for a successful dispatch, the job.
// Each command sends one scan beat down a chain of JOB_SLOTS job cells, one
// cell per cycle, collecting the best eligible job, duplicate and lowest free
// slot. The command is then applied in the finish state, which waits until
// the output register is free. One command is in flight at a time: a new
// command is taken only in the idle state, once the last one is done.
// The result is held in an output register; a stalled receiver delays only
// the commit of the next command, which then waits with its scan done.
// Reset empties both the job table and the lock table at once; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module grouped_priority_dispatcher_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    action_i,
  input  logic [gpd_pkg::IDENT_W-1:0]   job_ident_i,
  input  logic [gpd_pkg::PRIO_W-1:0]    job_priority_i,
  input  logic [gpd_pkg::GROUP_W-1:0]   group_ident_i,
  input  logic [1:0]                    job_category_i,
  input  logic                          locks_group_i,
  input  logic                          local_free_i,
  input  logic                          judge_free_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [gpd_pkg::IDENT_W-1:0]   out_job_ident_o,
  output logic [gpd_pkg::GROUP_W-1:0]   out_group_ident_o,
  output logic [1:0]                    out_category_o,
  output logic                          out_pool_o,
  output logic                          out_locks_group_o
);
  import gpd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   start_q;
  logic [1:0]         act_q;
  req_t               req_q;
  entry_t             add_q;
  logic [GROUP_W-1:0] grp_q;
  scan_t              fc_q;

  scan_t [JOB_SLOTS-1:0] chain;
  scan_t                 head;
  logic [JOB_SLOTS-1:0]  set_v, clr_v, tok_v;
  logic                  set_en, clr_en;

  logic [LOCK_SLOTS-1:0]              lk_vld;
  logic [LOCK_SLOTS-1:0][GROUP_W-1:0] lk_grp;
  lock_stat_t                         lk_stat;
  logic [GROUP_W-1:0]                 lk_query;
  logic                               take, rel, blocks;

  logic               fin_go;
  logic               out_valid_q;
  logic [2:0]         st_d, status_q;
  logic [IDENT_W-1:0] oid_d, oid_q;
  logic [GROUP_W-1:0] ogr_d, ogr_q;
  logic [1:0]         ocat_d, ocat_q;
  logic               opool_d, opool_q, olock_d, olock_q;
  logic [1:0]         cat_n;

  assign in_ready_o = (state_q == S_IDLE);
  assign fin_go     = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign cat_n      = (job_category_i == 2'd3) ? CAT_OTHER : job_category_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN:  if (chain[JOB_SLOTS-1].vld) state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= in_valid_i && in_ready_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q            <= action_i;
      req_q.ident      <= job_ident_i;
      req_q.local_free <= local_free_i;
      req_q.judge_free <= judge_free_i;
      grp_q            <= group_ident_i;
      add_q.ident      <= job_ident_i;
      add_q.prio       <= job_priority_i;
      add_q.cat        <= cat_n;
      add_q.group      <= (cat_n == CAT_OTHER) ? '0 : group_ident_i;
      add_q.locks      <= (cat_n == CAT_OTHER) ? 1'b0 : locks_group_i;
    end
    if (state_q == S_SCAN && chain[JOB_SLOTS-1].vld) begin
      fc_q <= chain[JOB_SLOTS-1];
    end
  end

  always_comb begin
    head     = '0;
    head.vld = start_q;
  end

  for (genvar g = 0; g < JOB_SLOTS; g++) begin : g_cell
    gpd_job_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .slot_i   (SLOT_W'(g)),
      .set_i    (set_v[g]),
      .clr_i    (clr_v[g]),
      .wr_i     (add_q),
      .req_i    (req_q),
      .lk_vld_i (lk_vld),
      .lk_grp_i (lk_grp),
      .scan_i   ((g == 0) ? head : chain[(g == 0) ? 0 : g-1]),
      .scan_o   (chain[g])
    );
    assign set_v[g] = set_en && (fc_q.free_slot == SLOT_W'(g));
    assign clr_v[g] = clr_en && (fc_q.slot == SLOT_W'(g));
    assign tok_v[g] = chain[g].vld;
  end

  assign lk_query = (act_q == ACT_DISP) ? fc_q.group : grp_q;

  gpd_lock_table u_locks (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .group_i   (lk_query),
    .take_i    (take),
    .release_i (rel),
    .stat_o    (lk_stat),
    .lk_vld_o  (lk_vld),
    .lk_grp_o  (lk_grp)
  );

  always_comb begin
    st_d    = ST_OK;
    oid_d   = '0;
    ogr_d   = '0;
    ocat_d  = '0;
    opool_d = 1'b0;
    olock_d = 1'b0;
    take    = 1'b0;
    rel     = 1'b0;
    set_en  = 1'b0;
    clr_en  = 1'b0;
    blocks  = fc_q.locks;
    unique case (act_q)
      ACT_ADD: begin
        if (fc_q.dup) st_d = ST_DUP;
        else if (!fc_q.free_hit) st_d = ST_JOB_FULL;
        else set_en = fin_go;
      end
      ACT_LOCK: begin
        if (lk_stat.possible) take = fin_go;
        else st_d = ST_LOCK_FULL;
      end
      ACT_UNLOCK: begin
        if (lk_stat.found) rel = fin_go;
        else st_d = ST_NOT_LOCKD;
      end
      default: begin
        if (!fc_q.hit) begin
          st_d = ST_NONE;
        end else if (blocks && !lk_stat.possible) begin
          st_d = ST_LOCK_FULL;
        end else begin
          take    = fin_go && blocks;
          clr_en  = fin_go;
          oid_d   = fc_q.ident;
          ogr_d   = fc_q.group;
          ocat_d  = fc_q.cat;
          opool_d = (fc_q.cat == CAT_JUDGE);
          olock_d = blocks;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      status_q <= st_d;
      oid_q    <= oid_d;
      ogr_q    <= ogr_d;
      ocat_q   <= ocat_d;
      opool_q  <= opool_d;
      olock_q  <= olock_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign out_job_ident_o   = oid_q;
  assign out_group_ident_o = ogr_q;
  assign out_category_o    = ocat_q;
  assign out_pool_o        = opool_q;
  assign out_locks_group_o = olock_q;

`include "grouped_priority_dispatcher_core_assert.svh"

  `GPD_ASSERT_NOW(a_one_token, 1'b1, $onehot0({tok_v, start_q}))
  `GPD_ASSERT_NOW(a_token_only_in_scan, tok_v != '0, state_q == S_SCAN)
  `GPD_ASSERT_NEXT(a_fin_gives_beat, fin_go, out_valid_o && state_q == S_IDLE)
  `GPD_ASSERT_NOW(a_no_dual_lock_op, 1'b1, !(take && rel))

endmodule
